/* hw/rtl/sacache_pkg.sv */
// Shared types and constants for the set-associative write-back cache.
// Used by the front, back and top-level modules; depends on nothing.
`default_nettype none

package sacache_pkg;

  localparam int TAG_W     = 32;
  localparam int SET_W     = 13;
  localparam int OFF_W     = 10;
  localparam int SIZE_W    = 4;
  localparam int CNT_W     = 32;
  localparam int CFG_W     = 4;
  localparam int IB_CAP    = 13;
  localparam int OB_CAP    = 10;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_INDEX_BITS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WAYS        = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_BITS = 2'd2;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_SIZE  = 2'd1,
    ERR_ALIGN = 2'd2
  } err_code_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOKUP
  } back_state_t;

  typedef struct packed {
    logic              func;
    logic [SIZE_W-1:0] access_size;
    logic [TAG_W-1:0]  address;
  } in_t;

  // Configuration after saturation to the supported ranges.
  typedef struct packed {
    logic [CFG_W-1:0] index_bits;
    logic [CFG_W-1:0] ways;
    logic [CFG_W-1:0] offset_bits;
  } cfg_eff_t;

  // Classified access travelling from the front to the back.
  typedef struct packed {
    err_code_t        error_code;
    logic             func;
    logic [CFG_W-1:0] nways;
    logic [TAG_W-1:0] tag;
    logic [SET_W-1:0] set_index;
    logic [OFF_W-1:0] byte_offset;
  } item_t;

  typedef struct packed {
    err_code_t        error_code;
    logic             hit;
    logic [1:0]       mem_refs;
    logic [TAG_W-1:0] tag_out;
    logic [SET_W-1:0] set_index;
    logic [OFF_W-1:0] byte_offset;
    logic [CNT_W-1:0] ref_number;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
  } out_t;

endpackage

`default_nettype wire

/* hw/rtl/sacache_fifo.sv */
// Small synchronous queue used between the front and back and on the result side.
// Stand-alone; the payload is a flat vector of WIDTH bits.
`default_nettype none

module sacache_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sacache_front.sv */
// Front end: accepts accesses, checks size and alignment and splits the address.
// Depends on sacache_pkg; feeds the queue in front of sacache_back.
`default_nettype none

module sacache_front (
  input  logic                  push,
  output logic                  full,
  input  sacache_pkg::in_t      in_data,
  input  sacache_pkg::cfg_eff_t cfg,
  input  logic                  clearing,
  input  logic                  q_full,
  output logic                  q_push,
  output sacache_pkg::item_t    q_data
);
  import sacache_pkg::*;

  logic             size_ok;
  logic             misaligned;
  logic [TAG_W-1:0] ones;
  logic [TAG_W-1:0] above_off;
  logic [4:0]       tag_shift;

  assign full   = clearing || q_full;
  assign q_push = push && !full;
  assign ones   = '1;

  always_comb begin
    size_ok    = in_data.access_size inside {4'd1, 4'd2, 4'd4, 4'd8};
    misaligned = (in_data.address[2:0] & (in_data.access_size[2:0] - 3'd1)) != 3'd0;
    above_off  = in_data.address >> cfg.offset_bits;
    tag_shift  = {1'b0, cfg.offset_bits} + {1'b0, cfg.index_bits};

    q_data       = '0;
    q_data.func  = in_data.func;
    q_data.nways = cfg.ways;
    if (!size_ok) begin
      q_data.error_code = ERR_SIZE;
    end else if (misaligned) begin
      q_data.error_code = ERR_ALIGN;
    end else begin
      q_data.error_code  = ERR_NONE;
      q_data.byte_offset = OFF_W'(in_data.address & ~(ones << cfg.offset_bits));
      q_data.set_index   = SET_W'(above_off & ~(ones << cfg.index_bits));
      q_data.tag         = in_data.address >> tag_shift;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sacache_back.sv */
// Back end: set memory with tags, valid, dirty and LRU ranks, plus the running totals.
// Depends on sacache_pkg; reads classified accesses and writes results to queues.
`default_nettype none

module sacache_back #(
  parameter int MAX_SET_COUNT = 8192,
  parameter int MAX_WAYS      = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               q_pop,
  input  sacache_pkg::item_t q_data,
  input  logic               res_full,
  output logic               res_push,
  output sacache_pkg::out_t  res_data,
  output logic               clearing
);
  import sacache_pkg::*;

  localparam int IDX_W = (MAX_SET_COUNT > 1) ? $clog2(MAX_SET_COUNT) : 1;
  localparam int RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic [RW-1:0]    rank;
  } way_t;

  typedef way_t [MAX_WAYS-1:0] row_t;

  row_t        mem [MAX_SET_COUNT];
  row_t        rd_row_r;
  row_t        upd_row;
  row_t        mem_wdata;
  logic        mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;

  back_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0] ref_cnt_r, ref_cnt_nxt;
  logic [CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0] miss_cnt_r, miss_cnt_nxt;
  item_t            cur_r;

  logic          found;
  logic          victim_seen;
  logic [RW-1:0] hway, victim, top, hrank;
  logic [1:0]    mrefs;

  assign clearing = (state_r == BK_CLEAR);

  // Tag compare, victim choice and LRU rank update on the row read last cycle.
  always_comb begin
    found       = 1'b0;
    hway        = '0;
    victim_seen = 1'b0;
    victim      = '0;
    top         = RW'(cur_r.nways - 4'd1);
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i < int'(cur_r.nways) && rd_row_r[i].valid && rd_row_r[i].tag == cur_r.tag) begin
        found = 1'b1;
        hway  = RW'(i);
      end
      if (i < int'(cur_r.nways) && rd_row_r[i].rank == '0 && !victim_seen) begin
        victim_seen = 1'b1;
        victim      = RW'(i);
      end
    end
    hrank   = rd_row_r[hway].rank;
    upd_row = rd_row_r;
    mrefs   = 2'd0;
    if (found) begin
      if (cur_r.func) begin
        upd_row[hway].dirty = 1'b1;
      end
      if (hrank != top) begin
        for (int i = 0; i < MAX_WAYS; i++) begin
          if (i < int'(cur_r.nways) && rd_row_r[i].rank > hrank) begin
            upd_row[i].rank = rd_row_r[i].rank - 1'b1;
          end
        end
        upd_row[hway].rank = top;
      end
    end else begin
      mrefs = rd_row_r[victim].dirty ? 2'd2 : 2'd1;
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (i < int'(cur_r.nways) && rd_row_r[i].rank != '0) begin
          upd_row[i].rank = rd_row_r[i].rank - 1'b1;
        end
      end
      upd_row[victim].tag   = cur_r.tag;
      upd_row[victim].valid = 1'b1;
      upd_row[victim].dirty = cur_r.func;
      upd_row[victim].rank  = top;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    ref_cnt_nxt  = ref_cnt_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    q_pop        = 1'b0;
    res_push     = 1'b0;
    res_data     = '0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = IDX_W'(cur_r.set_index);
    mem_raddr    = IDX_W'(q_data.set_index);
    mem_wdata    = upd_row;
    case (state_r)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
        if (clr_idx_r == IDX_W'(MAX_SET_COUNT - 1)) begin
          state_nxt = BK_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      BK_IDLE: begin
        if (!q_empty && !res_full) begin
          q_pop = 1'b1;
          if (q_data.error_code != ERR_NONE) begin
            // Rejected accesses bypass the set memory and leave the totals alone.
            res_push            = 1'b1;
            res_data.error_code = q_data.error_code;
            res_data.ref_number = ref_cnt_r;
            res_data.hit_total  = hit_cnt_r;
            res_data.miss_total = miss_cnt_r;
          end else begin
            mem_re    = 1'b1;
            state_nxt = BK_LOOKUP;
          end
        end
      end
      BK_LOOKUP: begin
        mem_we      = 1'b1;
        res_push    = 1'b1;
        ref_cnt_nxt = ref_cnt_r + 1'b1;
        if (found) begin
          hit_cnt_nxt = hit_cnt_r + 1'b1;
        end else begin
          miss_cnt_nxt = miss_cnt_r + 1'b1;
        end
        res_data.error_code  = ERR_NONE;
        res_data.hit         = found;
        res_data.mem_refs    = mrefs;
        res_data.tag_out     = cur_r.tag;
        res_data.set_index   = cur_r.set_index;
        res_data.byte_offset = cur_r.byte_offset;
        res_data.ref_number  = ref_cnt_nxt;
        res_data.hit_total   = hit_cnt_nxt;
        res_data.miss_total  = miss_cnt_nxt;
        state_nxt            = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_CLEAR;
      clr_idx_r  <= '0;
      ref_cnt_r  <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_idx_r  <= clr_idx_nxt;
      ref_cnt_r  <= ref_cnt_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_r <= mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/set_assoc_writeback_cache_lru.sv */
// Set-associative write-back, write-allocate cache tracker with per-set LRU ranks.
// Access queue side: drive in_data and raise push; the access is taken on a clock
// edge where push is high and full is low. Result side: while empty is low the
// oldest result sits on out_data, and it is taken on an edge where pop is high.
// Each access gives exactly one result, in order. A rejected access (bad size or
// misaligned) goes from the front queue straight into the result queue; a legal
// access goes through the back end as a set read, then compare and write back, and
// the back end takes no new access until the current one has been written back.
// The front queue holds two accesses and the result queue two results, so
// accesses keep being taken while results wait; once the result queue is full
// the back end holds and the front queue then fills and raises full.
// After reset the set memory is cleared one set per cycle, all MAX_SET_COUNT sets,
// with full held high; configuration writes are taken during that time.
// Configuration registers (APB, byte address 4*i): index_bits, ways, offset_bits.
// Depends on sacache_pkg, sacache_front, sacache_fifo and sacache_back.
`default_nettype none

module set_assoc_writeback_cache_lru #(
  parameter int MAX_SET_COUNT = 8192,
  parameter int MAX_WAYS      = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  sacache_pkg::in_t                    in_data,
  output logic                                empty,
  input  logic                                pop,
  output sacache_pkg::out_t                   out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sacache_pkg::PADDR_W-1:0]     paddr,
  input  logic [sacache_pkg::PDATA_W-1:0]     pwdata,
  output logic [sacache_pkg::PDATA_W-1:0]     prdata,
  output logic                                pready
);
  import sacache_pkg::*;

  localparam int SET_LOG = ((1 << $clog2(MAX_SET_COUNT)) == MAX_SET_COUNT)
                           ? $clog2(MAX_SET_COUNT) : $clog2(MAX_SET_COUNT) - 1;
  localparam int MAX_IB  = (SET_LOG > IB_CAP) ? IB_CAP : SET_LOG;

  logic [CFG_W-1:0]     index_bits_r, ways_r, offset_bits_r;
  logic [CFG_W-1:0]     ways_min1;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  cfg_eff_t             cfg_eff;

  logic  clearing;
  logic  mid_push, mid_full, mid_pop, mid_empty;
  item_t mid_wdata, mid_rdata;
  logic  res_push, res_full;
  out_t  res_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_INDEX_BITS:  prdata = PDATA_W'(index_bits_r);
      REG_WAYS:        prdata = PDATA_W'(ways_r);
      REG_OFFSET_BITS: prdata = PDATA_W'(offset_bits_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_bits_r  <= 4'd6;
      ways_r        <= 4'd4;
      offset_bits_r <= 4'd4;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_INDEX_BITS:  index_bits_r  <= pwdata[CFG_W-1:0];
        REG_WAYS:        ways_r        <= pwdata[CFG_W-1:0];
        REG_OFFSET_BITS: offset_bits_r <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Out-of-range settings saturate to what the storage supports.
  always_comb begin
    ways_min1           = (ways_r == '0) ? CFG_W'(1) : ways_r;
    cfg_eff.index_bits  = (int'(index_bits_r) > MAX_IB) ? CFG_W'(MAX_IB) : index_bits_r;
    cfg_eff.offset_bits = (int'(offset_bits_r) > OB_CAP) ? CFG_W'(OB_CAP) : offset_bits_r;
    cfg_eff.ways        = (int'(ways_min1) > MAX_WAYS) ? CFG_W'(MAX_WAYS) : ways_min1;
  end

  sacache_front u_front (
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .cfg      (cfg_eff),
    .clearing (clearing),
    .q_full   (mid_full),
    .q_push   (mid_push),
    .q_data   (mid_wdata)
  );

  sacache_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (2)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  sacache_back #(
    .MAX_SET_COUNT (MAX_SET_COUNT),
    .MAX_WAYS      (MAX_WAYS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (mid_empty),
    .q_pop    (mid_pop),
    .q_data   (mid_rdata),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data),
    .clearing (clearing)
  );

  sacache_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> full)
    else $error("access queue open during set memory clear");

  a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written into a full result queue");

  a_hit_no_refs: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.hit) |-> (out_data.mem_refs == 2'd0))
    else $error("hit result reports memory references");

  a_totals_add_up: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.ref_number == CNT_W'(out_data.hit_total + out_data.miss_total)))
    else $error("reference total differs from hits plus misses");

endmodule

`default_nettype wire

/* test/set_assoc_writeback_cache_lru_test.sv */
// Self-checking testbench for the set-associative write-back LRU cache tracker.
// Drives accesses and geometry registers, predicts every result with its own cache
// model and compares them in order. Depends on sacache_pkg and the top-level RTL.
module set_assoc_writeback_cache_lru_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sacache_pkg::*;

  localparam int LINE_WAYS = 8;
  localparam int LINE_COUNT = 8192 * LINE_WAYS;
  localparam logic ACC_READ = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_POP_STALLS, PACE_LIGHT} pace_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  in_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // Cache model state, one entry per set and way.
  bit [31:0] line_tag [LINE_COUNT];
  bit line_valid [LINE_COUNT];
  bit line_dirty [LINE_COUNT];
  bit [2:0] line_age [LINE_COUNT];
  logic [31:0] accesses = '0;
  logic [31:0] hits = '0;
  logic [31:0] misses = '0;
  int unsigned eff_ib = 6;
  int unsigned eff_ways = 4;
  int unsigned eff_ob = 4;

  out_t lookup_results [$];
  int mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;

  set_assoc_writeback_cache_lru DUT (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic out_t lookup_and_update(in_t a);
    out_t r;
    logic [31:0] off, rest, set, tag;
    int unsigned base, way, top, old, victim;
    bit found;
    r = '0;
    found = 1'b0;
    way = 0;
    if (a.access_size != 4'd1 && a.access_size != 4'd2 && a.access_size != 4'd4 &&
        a.access_size != 4'd8) begin
      r.error_code = ERR_SIZE;
    end else if ((a.address & (32'(a.access_size) - 32'd1)) != 32'd0) begin
      r.error_code = ERR_ALIGN;
    end
    if (r.error_code != ERR_NONE) begin
      r.ref_number = accesses;
      r.hit_total = hits;
      r.miss_total = misses;
      return r;
    end
    off = a.address & ((32'd1 << eff_ob) - 32'd1);
    rest = a.address >> eff_ob;
    set = rest & ((32'd1 << eff_ib) - 32'd1);
    tag = rest >> eff_ib;
    base = set * LINE_WAYS;
    top = eff_ways - 1;
    accesses++;
    // The highest matching way wins when a reconfiguration left duplicates behind.
    for (int i = 0; i < int'(eff_ways); i++) begin
      if (line_valid[base + i] && line_tag[base + i] == tag) begin
        found = 1'b1;
        way = i;
      end
    end
    if (found) begin
      if (a.func == ACC_WRITE) line_dirty[base + way] = 1'b1;
      old = line_age[base + way];
      if (old != top) begin
        for (int i = 0; i < int'(eff_ways); i++) begin
          if (line_age[base + i] > old) line_age[base + i]--;
        end
        line_age[base + way] = 3'(top);
      end
      hits++;
    end else begin
      // The lowest way of rank zero is evicted; way 0 if none has rank zero.
      victim = 0;
      for (int i = int'(eff_ways) - 1; i >= 0; i--) begin
        if (line_age[base + i] == 3'd0) victim = i;
      end
      r.mem_refs = line_dirty[base + victim] ? 2'd2 : 2'd1;
      line_dirty[base + victim] = (a.func == ACC_WRITE);
      line_valid[base + victim] = 1'b1;
      line_tag[base + victim] = tag;
      for (int i = 0; i < int'(eff_ways); i++) begin
        if (line_age[base + i] > 3'd0) line_age[base + i]--;
      end
      line_age[base + victim] = 3'(top);
      misses++;
    end
    r.hit = found;
    r.tag_out = tag;
    r.set_index = set[SET_W-1:0];
    r.byte_offset = off[OFF_W-1:0];
    r.ref_number = accesses;
    r.hit_total = hits;
    r.miss_total = misses;
    return r;
  endfunction

  // Mostly legal accesses to a few sets and tags so that hits and evictions
  // are common; the rest is fully random.
  function automatic in_t make_access();
    in_t a;
    logic [63:0] addr;
    logic [31:0] tag, set_sel;
    a.func = 1'($urandom_range(1));
    if ($urandom_range(99) < 12) begin
      a.access_size = 4'($urandom_range(15));
      a.address = $urandom;
    end else begin
      a.access_size = 4'd1 << $urandom_range(3);
      tag = ($urandom_range(15) == 0) ? $urandom : $urandom_range(eff_ways + 2);
      set_sel = ($urandom_range(4) == 0) ? $urandom : $urandom_range(3);
      addr = (64'(tag) << (eff_ib + eff_ob))
           | (64'(set_sel & ((32'd1 << eff_ib) - 32'd1)) << eff_ob)
           | 64'($urandom & ((32'd1 << eff_ob) - 32'd1));
      a.address = addr[31:0] & ~(32'(a.access_size) - 32'd1);
    end
    return a;
  endfunction

  task automatic set_pace(input pace_t p);
    case (p)
      PACE_FULL: begin
        send_idle_pct = 0;
        pop_stall_pct = 0;
      end
      PACE_SEND_GAPS: begin
        send_idle_pct = 74;
        pop_stall_pct = 0;
      end
      PACE_POP_STALLS: begin
        send_idle_pct = 0;
        pop_stall_pct = 74;
      end
      default: begin
        send_idle_pct = 10;
        pop_stall_pct = 10;
      end
    endcase
  endtask

  task automatic send_access(input in_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= a;
    do @(posedge clk); while (full);
    lookup_results.insert(lookup_results.size(), lookup_and_update(a));
  endtask

  // Waits until every outstanding result has been taken and the block is quiet.
  task automatic settle();
    push <= 1'b0;
    while (lookup_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_transfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_geometry(input logic [3:0] ib, input logic [3:0] nw,
                                  input logic [3:0] ob);
    logic [31:0] rd;
    logic [3:0] vals [3];
    logic [REG_IDX_W-1:0] regs [3];
    settle();
    vals = '{ib, nw, ob};
    regs = '{REG_INDEX_BITS, REG_WAYS, REG_OFFSET_BITS};
    for (int i = 0; i < 3; i++) begin
      apb_transfer(1'b1, regs[i], 32'(vals[i]), rd);
      apb_transfer(1'b0, regs[i], 32'd0, rd);
      if (rd != 32'(vals[i])) begin
        $error("register %0d readback: expected %0d, got %0d", regs[i], vals[i], rd);
        mismatches++;
      end
    end
    eff_ib = (ib > IB_CAP) ? IB_CAP : ib;
    eff_ob = (ob > OB_CAP) ? OB_CAP : ob;
    eff_ways = (nw == 4'd0) ? 1 : ((nw > LINE_WAYS) ? LINE_WAYS : nw);
  endtask

  // Bad sizes come before misalignment; both leave the cache untouched.
  task automatic test_rejected_accesses();
    send_access(in_t'{ACC_READ, 4'd0, 32'h0000_0000});
    send_access(in_t'{ACC_WRITE, 4'd3, 32'h0000_0000});
    send_access(in_t'{ACC_WRITE, 4'd15, 32'h0000_0001});
    send_access(in_t'{ACC_READ, 4'd2, 32'h0000_0001});
    send_access(in_t'{ACC_WRITE, 4'd4, 32'h0000_0002});
    send_access(in_t'{ACC_READ, 4'd8, 32'hFFFF_FFFC});
  endtask

  task automatic test_address_extremes();
    send_access(in_t'{ACC_READ, 4'd8, 32'h0000_0000});
    send_access(in_t'{ACC_WRITE, 4'd1, 32'h0000_000F});
    send_access(in_t'{ACC_WRITE, 4'd8, 32'hFFFF_FFF8});
    send_access(in_t'{ACC_READ, 4'd1, 32'hFFFF_FFFF});
    send_access(in_t'{ACC_READ, 4'd4, 32'h0000_03F0});
  endtask

  // Five write tags into one four-way set, then a read of the first: both
  // replacements hit a dirty victim.
  task automatic test_dirty_eviction();
    for (int t = 1; t <= 5; t++) begin
      send_access(in_t'{ACC_WRITE, 4'd4, (32'(t) << 10) | 32'h10});
    end
    send_access(in_t'{ACC_READ, 4'd4, 32'h0000_0410});
  endtask

  // Shrinking the ways can leave no way of rank zero in the live range, and
  // growing them again can expose the same tag in two ways of one set.
  task automatic test_reconfig_corners();
    program_geometry(4'd0, 4'd8, 4'd0);
    for (int t = 0; t < 8; t++) send_access(in_t'{ACC_READ, 4'd1, 32'(t)});
    program_geometry(4'd0, 4'd4, 4'd0);
    send_access(in_t'{ACC_WRITE, 4'd1, 32'd7});
    program_geometry(4'd0, 4'd8, 4'd0);
    send_access(in_t'{ACC_READ, 4'd1, 32'd7});
  endtask

  task automatic test_random_geometries();
    logic [3:0] geo [12][3];
    geo = '{'{4'd6, 4'd4, 4'd4}, '{4'd0, 4'd1, 4'd0}, '{4'd13, 4'd8, 4'd10},
            '{4'd15, 4'd15, 4'd15}, '{4'd2, 4'd0, 4'd3}, '{4'd3, 4'd2, 4'd2},
            '{4'd1, 4'd8, 4'd0}, '{4'd4, 4'd3, 4'd5}, '{4'd0, 4'd8, 4'd6},
            '{4'd13, 4'd1, 4'd0}, '{4'd12, 4'd5, 4'd11}, '{4'd5, 4'd7, 4'd1}};
    for (int p = 0; p < 12; p++) begin
      program_geometry(geo[p][0], geo[p][1], geo[p][2]);
      set_pace(pace_t'(p % 4));
      repeat (96) send_access(make_access());
    end
    set_pace(PACE_FULL);
  endtask

  always @(posedge clk) pop <= rst_n && ($urandom_range(99) >= pop_stall_pct);

  always @(posedge clk) begin
    out_t want;
    if (rst_n && pop && !empty) begin
      if (lookup_results.size() == 0) begin
        $error("result transaction with no access outstanding");
        mismatches++;
      end else begin
        want = lookup_results.pop_front();
        if (out_data.error_code != want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_data.error_code);
          mismatches++;
        end
        if (out_data.hit != want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_data.hit);
          mismatches++;
        end
        if (out_data.mem_refs != want.mem_refs) begin
          $error("mem_refs: expected %0d, got %0d", want.mem_refs, out_data.mem_refs);
          mismatches++;
        end
        if (out_data.tag_out != want.tag_out) begin
          $error("tag_out: expected %h, got %h", want.tag_out, out_data.tag_out);
          mismatches++;
        end
        if (out_data.set_index != want.set_index) begin
          $error("set_index: expected %0d, got %0d", want.set_index, out_data.set_index);
          mismatches++;
        end
        if (out_data.byte_offset != want.byte_offset) begin
          $error("byte_offset: expected %0d, got %0d", want.byte_offset,
                 out_data.byte_offset);
          mismatches++;
        end
        if (out_data.ref_number != want.ref_number) begin
          $error("ref_number: expected %0d, got %0d", want.ref_number, out_data.ref_number);
          mismatches++;
        end
        if (out_data.hit_total != want.hit_total) begin
          $error("hit_total: expected %0d, got %0d", want.hit_total, out_data.hit_total);
          mismatches++;
        end
        if (out_data.miss_total != want.miss_total) begin
          $error("miss_total: expected %0d, got %0d", want.miss_total, out_data.miss_total);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // The registers accept writes while the set memory is still being cleared.
    program_geometry(4'd6, 4'd4, 4'd4);
    set_pace(PACE_FULL);
    test_rejected_accesses();
    test_address_extremes();
    test_dirty_eviction();
    test_reconfig_corners();
    test_random_geometries();
    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
